// File: rtl/dcr_pkg.sv
`timescale 1ns / 1ps

// Shared constants and types of the depth-to-color registration pipeline.
package dcr_pkg;

  // Field and datapath widths.
  localparam int COEF_W     = 48;
  localparam int FRAC_BITS  = 32;
  localparam int ACC_W      = 64;
  localparam int NUM_COEF   = 27;
  localparam int COEF_IDX_W = 5;
  localparam int DIM_W      = 13;
  localparam int MAX_DIM    = 4096;
  localparam int PIX_W      = 12;
  localparam int DEPTH_W    = 16;
  localparam int OUT_W      = 16;
  localparam int ST_W       = 2;

  // Quotient bits produced by the divider; larger quotients saturate.
  localparam int DIV_BITS   = OUT_W - 1;

  // Latency of one three-term dot product unit.
  localparam int DOT_LAT    = 8;

  typedef logic signed [ACC_W-1:0]  acc_t;
  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic [DIM_W-1:0]         dim_t;

  localparam acc_t SAT_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam acc_t SAT_MIN = -SAT_MAX;

  // Request kinds.
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_MAP  = 1'b1;

  // Configuration register indexes.
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // Result status codes.
  localparam logic [ST_W-1:0] ST_INSIDE     = 2'd0;
  localparam logic [ST_W-1:0] ST_ZERO_DEPTH = 2'd1;
  localparam logic [ST_W-1:0] ST_ZERO_DIV   = 2'd2;
  localparam logic [ST_W-1:0] ST_OUTSIDE    = 2'd3;

  // Special-case flags that travel with a pixel.
  typedef struct packed {
    logic zero_depth;
    logic zero_div;
  } flags_t;

endpackage

// File: rtl/dcr_mulq.sv
`timescale 1ns / 1ps

// Fixed-point product a*b / 2^FRAC_BITS, truncated toward zero and
// saturated to +-(2^63-1). Five register stages, 32x32 and 32x16 pieces.
module dcr_mulq (
  input  logic          clk_i,
  input  logic          en_i,
  input  dcr_pkg::acc_t a_i,
  input  dcr_pkg::coef_t b_i,
  output dcr_pkg::acc_t r_o
);

  logic         neg1_q, neg2_q, neg3_q, neg4_q;
  logic [63:0]  ma_q;
  logic [47:0]  mb_q;
  logic [63:0]  p00_q, p10_q;
  logic [47:0]  p01_q, p11_q;
  logic [64:0]  mid_q;
  logic [63:0]  lo_q;
  logic [47:0]  hi_q;
  logic [111:0] full_q;
  logic [111-dcr_pkg::FRAC_BITS:0] shifted;
  logic         sat;
  logic [63:0]  mag;
  dcr_pkg::acc_t r_q;

  // Stage 1: magnitudes and result sign.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg1_q <= (a_i[63] != b_i[47]);
      ma_q   <= a_i[63] ? 64'(-a_i) : 64'(a_i);
      mb_q   <= b_i[47] ? 48'(-b_i) : 48'(b_i);
    end
  end

  // Stage 2: four partial products.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg2_q <= neg1_q;
      p00_q  <= 64'(ma_q[31:0]) * 64'(mb_q[31:0]);
      p01_q  <= 48'(ma_q[31:0]) * 48'(mb_q[47:32]);
      p10_q  <= 64'(ma_q[63:32]) * 64'(mb_q[31:0]);
      p11_q  <= 48'(ma_q[63:32]) * 48'(mb_q[47:32]);
    end
  end

  // Stage 3: sum of the middle products.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg3_q <= neg2_q;
      mid_q  <= 65'(p01_q) + 65'(p10_q);
      lo_q   <= p00_q;
      hi_q   <= p11_q;
    end
  end

  // Stage 4: full product.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg4_q <= neg3_q;
      full_q <= {hi_q, lo_q} + (112'(mid_q) << 32);
    end
  end

  // Stage 5: drop the fraction, saturate and restore the sign.
  always_comb begin
    shifted = full_q[111:dcr_pkg::FRAC_BITS];
    sat     = |shifted[111-dcr_pkg::FRAC_BITS:63];
    mag     = sat ? 64'(dcr_pkg::SAT_MAX) : {1'b0, shifted[62:0]};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q <= neg4_q ? dcr_pkg::acc_t'(-mag) : dcr_pkg::acc_t'(mag);
    end
  end

  assign r_o = r_q;

endmodule

// File: rtl/dcr_dot3.sv
`timescale 1ns / 1ps

// Saturating dot product: ((init + x0*c0) + x1*c1) + x2*c2, each product
// a fixed-point product and each sum saturated in that order.
module dcr_dot3 (
  input  logic           clk_i,
  input  logic           en_i,
  input  dcr_pkg::acc_t  x_i [3],
  input  dcr_pkg::coef_t c_i [3],
  input  dcr_pkg::acc_t  init_i,
  output dcr_pkg::acc_t  sum_o
);

  dcr_pkg::acc_t m [3];
  dcr_pkg::acc_t a1_q, a2_q, a3_q;
  dcr_pkg::acc_t m1_q, m2_q, m2b_q;

  function automatic dcr_pkg::acc_t add_sat(dcr_pkg::acc_t a, dcr_pkg::acc_t b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s > 65'(dcr_pkg::SAT_MAX)) begin
      return dcr_pkg::SAT_MAX;
    end else if (s < 65'(dcr_pkg::SAT_MIN)) begin
      return dcr_pkg::SAT_MIN;
    end
    return s[63:0];
  endfunction

  // Three product units in parallel.
  for (genvar i = 0; i < 3; i++) begin : g_mul
    dcr_mulq u_mulq (
      .clk_i (clk_i),
      .en_i  (en_i),
      .a_i   (x_i[i]),
      .b_i   (c_i[i]),
      .r_o   (m[i])
    );
  end

  // One saturating add per stage, in the accumulation order.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a1_q  <= add_sat(init_i, m[0]);
      m1_q  <= m[1];
      m2_q  <= m[2];
      a2_q  <= add_sat(a1_q, m1_q);
      m2b_q <= m2_q;
      a3_q  <= add_sat(a2_q, m2b_q);
    end
  end

  assign sum_o = a3_q;

endmodule

// File: rtl/dcr_front.sv
`timescale 1ns / 1ps

// Back-projection of the depth pixel: p = [col,row,1]*KI, scaled by depth
// and saturated. Four register stages.
module dcr_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          vld_i,
  input  logic [dcr_pkg::PIX_W-1:0]     col_i,
  input  logic [dcr_pkg::PIX_W-1:0]     row_i,
  input  logic [dcr_pkg::DEPTH_W-1:0]   depth_i,
  input  dcr_pkg::coef_t                ki_i [9],
  output logic                          vld_o,
  output logic                          zd_o,
  output dcr_pkg::acc_t                 q_o [3],
  output logic                          busy_o
);

  logic [3:0] vld_q;
  logic [3:0] zd_q;
  logic signed [60:0] pcol_q [3];
  logic signed [60:0] prow_q [3];
  logic signed [62:0] p_q [3];
  logic signed [79:0] prod_q [3];
  dcr_pkg::acc_t      q_q [3];
  logic [dcr_pkg::DEPTH_W-1:0] depth1_q, depth2_q;

  // Valid and zero-depth flags follow the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[2:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zd_q <= {zd_q[2:0], (depth_i == '0)};
    end
  end

  // Stage 1 and 2: products with the pixel position, then the sums.
  // Stage 3 and 4: depth scaling, then saturation.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      depth1_q <= depth_i;
      depth2_q <= depth1_q;
      for (int c = 0; c < 3; c++) begin
        pcol_q[c] <= 61'($signed({1'b0, col_i})) * 61'(ki_i[c]);
        prow_q[c] <= 61'($signed({1'b0, row_i})) * 61'(ki_i[3+c]);
        p_q[c]    <= 63'(pcol_q[c]) + 63'(prow_q[c]) + 63'(ki_i[6+c]);
        prod_q[c] <= 80'(p_q[c]) * 80'($signed({1'b0, depth2_q}));
        if (prod_q[c] > 80'(dcr_pkg::SAT_MAX)) begin
          q_q[c] <= dcr_pkg::SAT_MAX;
        end else if (prod_q[c] < 80'(dcr_pkg::SAT_MIN)) begin
          q_q[c] <= dcr_pkg::SAT_MIN;
        end else begin
          q_q[c] <= prod_q[c][63:0];
        end
      end
    end
  end

  assign vld_o  = vld_q[3];
  assign zd_o   = zd_q[3];
  assign q_o    = q_q;
  assign busy_o = |vld_q;

endmodule

// File: rtl/dcr_div.sv
`timescale 1ns / 1ps

// Signed division of both numerators by t2, truncated toward zero, one
// quotient bit per stage with an overflow test for saturation, then the
// image bounds test. Eighteen register stages.
module dcr_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         vld_i,
  input  dcr_pkg::flags_t              flags_i,
  input  dcr_pkg::acc_t                n0_i,
  input  dcr_pkg::acc_t                n1_i,
  input  dcr_pkg::acc_t                d_i,
  input  dcr_pkg::dim_t                width_i,
  input  dcr_pkg::dim_t                height_i,
  output logic                         vld_o,
  output logic [dcr_pkg::OUT_W-1:0]    col_o,
  output logic [dcr_pkg::OUT_W-1:0]    row_o,
  output logic [dcr_pkg::ST_W-1:0]     status_o,
  output logic                         busy_o
);

  localparam int NB = dcr_pkg::DIV_BITS;
  localparam int WW = 64 + NB;

  // Magnitude stage.
  logic            vld_a_q;
  dcr_pkg::flags_t fl_a_q;
  logic [63:0]     mn0_a_q, mn1_a_q, md_a_q;
  logic            neg0_a_q, neg1_a_q;

  // Iteration stages; index 0 is the overflow stage.
  logic [NB:0]       vld_s_q;
  dcr_pkg::flags_t   fl_s_q   [NB+1];
  logic [63:0]       rem0_s_q [NB+1];
  logic [63:0]       rem1_s_q [NB+1];
  logic [NB-1:0]     quo0_s_q [NB+1];
  logic [NB-1:0]     quo1_s_q [NB+1];
  logic [63:0]       md_s_q   [NB+1];
  logic              neg0_s_q [NB+1];
  logic              neg1_s_q [NB+1];
  logic              ovf0_s_q [NB+1];
  logic              ovf1_s_q [NB+1];

  // Output stage.
  logic                       vld_o_q;
  logic [dcr_pkg::OUT_W-1:0]  col_q, row_q;
  logic [dcr_pkg::ST_W-1:0]   status_q;

  logic [NB-1:0]              q0, q1;
  logic                       neg0, neg1, in_img;
  logic [dcr_pkg::OUT_W-1:0]  col_v, row_v;

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      vld_s_q <= '0;
      vld_o_q <= 1'b0;
    end else if (en_i) begin
      vld_a_q <= vld_i;
      vld_s_q <= {vld_s_q[NB-1:0], vld_a_q};
      vld_o_q <= vld_s_q[NB];
    end
  end

  // Magnitudes and quotient signs.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      fl_a_q   <= flags_i;
      mn0_a_q  <= n0_i[63] ? 64'(-n0_i) : 64'(n0_i);
      mn1_a_q  <= n1_i[63] ? 64'(-n1_i) : 64'(n1_i);
      md_a_q   <= d_i[63] ? 64'(-d_i) : 64'(d_i);
      neg0_a_q <= (n0_i[63] != d_i[63]);
      neg1_a_q <= (n1_i[63] != d_i[63]);
    end
  end

  // Overflow when the quotient would not fit in the saturating range.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      fl_s_q[0]   <= fl_a_q;
      rem0_s_q[0] <= mn0_a_q;
      rem1_s_q[0] <= mn1_a_q;
      quo0_s_q[0] <= '0;
      quo1_s_q[0] <= '0;
      md_s_q[0]   <= md_a_q;
      neg0_s_q[0] <= neg0_a_q;
      neg1_s_q[0] <= neg1_a_q;
      ovf0_s_q[0] <= (WW'(mn0_a_q) >= (WW'(md_a_q) << NB));
      ovf1_s_q[0] <= (WW'(mn1_a_q) >= (WW'(md_a_q) << NB));
    end
  end

  // Restoring division, most significant quotient bit first.
  for (genvar k = 0; k < NB; k++) begin : g_iter
    localparam int SH = NB - 1 - k;
    logic [WW-1:0] dsh;
    logic          ge0, ge1;

    always_comb begin
      dsh = WW'(md_s_q[k]) << SH;
      ge0 = (WW'(rem0_s_q[k]) >= dsh);
      ge1 = (WW'(rem1_s_q[k]) >= dsh);
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        fl_s_q[k+1]   <= fl_s_q[k];
        rem0_s_q[k+1] <= ge0 ? rem0_s_q[k] - dsh[63:0] : rem0_s_q[k];
        rem1_s_q[k+1] <= ge1 ? rem1_s_q[k] - dsh[63:0] : rem1_s_q[k];
        quo0_s_q[k+1] <= {quo0_s_q[k][NB-2:0], ge0};
        quo1_s_q[k+1] <= {quo1_s_q[k][NB-2:0], ge1};
        md_s_q[k+1]   <= md_s_q[k];
        neg0_s_q[k+1] <= neg0_s_q[k];
        neg1_s_q[k+1] <= neg1_s_q[k];
        ovf0_s_q[k+1] <= ovf0_s_q[k];
        ovf1_s_q[k+1] <= ovf1_s_q[k];
      end
    end
  end

  // Sign, saturation and bounds test.
  always_comb begin
    q0   = quo0_s_q[NB];
    q1   = quo1_s_q[NB];
    neg0 = neg0_s_q[NB] && (ovf0_s_q[NB] || (q0 != '0));
    neg1 = neg1_s_q[NB] && (ovf1_s_q[NB] || (q1 != '0));
    if (ovf0_s_q[NB]) begin
      col_v = neg0 ? {1'b1, {(dcr_pkg::OUT_W-1){1'b0}}} : {1'b0, {(dcr_pkg::OUT_W-1){1'b1}}};
    end else begin
      col_v = neg0 ? -{1'b0, q0} : {1'b0, q0};
    end
    if (ovf1_s_q[NB]) begin
      row_v = neg1 ? {1'b1, {(dcr_pkg::OUT_W-1){1'b0}}} : {1'b0, {(dcr_pkg::OUT_W-1){1'b1}}};
    end else begin
      row_v = neg1 ? -{1'b0, q1} : {1'b0, q1};
    end
    // The bounds are compared at the full quotient width.
    in_img = !ovf0_s_q[NB] && !neg0 && (q0 < NB'(width_i)) &&
             !ovf1_s_q[NB] && !neg1 && (q1 != '0) && (q1 < NB'(height_i));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (fl_s_q[NB].zero_depth) begin
        col_q    <= '0;
        row_q    <= '0;
        status_q <= dcr_pkg::ST_ZERO_DEPTH;
      end else if (fl_s_q[NB].zero_div) begin
        col_q    <= '0;
        row_q    <= '0;
        status_q <= dcr_pkg::ST_ZERO_DIV;
      end else begin
        col_q    <= col_v;
        row_q    <= row_v;
        status_q <= in_img ? dcr_pkg::ST_INSIDE : dcr_pkg::ST_OUTSIDE;
      end
    end
  end

  assign vld_o    = vld_o_q;
  assign col_o    = col_q;
  assign row_o    = row_q;
  assign status_o = status_q;
  assign busy_o   = vld_a_q || (|vld_s_q) || vld_o_q;

endmodule

// File: rtl/depth_to_color_registration_core.sv
`timescale 1ns / 1ps

// Depth-to-color pixel registration. Each map request carries one depth
// pixel and yields one result with the mapped color column and row and a
// status; a load request writes one of 27 Q15.32 coefficients and yields
// no result. Map requests are taken one per clock cycle as long as the
// result side keeps taking results, and each result passes through 4
// back-projection stages, two 8-stage dot-product units, an 18-stage
// divider and the output register; a stall on the result side holds the
// whole pipeline. A load request is taken only once no map request is in
// flight, so every pixel sees the coefficients that were loaded before
// it.
module depth_to_color_registration_core (
  input  logic        clk_i,
  input  logic        rst_ni,

  // Configuration writes: index 0 color width, index 1 color height.
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [12:0] cfg_data_i,

  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // coef_index[4:0], coef_value[52:5], pixel_col[64:53],
  // pixel_row[76:65], depth_raw[92:77], zero pad [95:93]
  input  logic [95:0] s_axis_tdata,
  // opcode[0]
  input  logic        s_axis_tuser,

  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // color_col[15:0], color_row[31:16]
  output logic [31:0] m_axis_tdata,
  // status[1:0]
  output logic [1:0]  m_axis_tuser
);

  localparam int DL = dcr_pkg::DOT_LAT;

  dcr_pkg::dim_t  width_q, height_q;
  dcr_pkg::dim_t  cfg_clamped;
  dcr_pkg::coef_t coef_q [dcr_pkg::NUM_COEF];

  logic adv, accept, busy, map_vld;
  logic [dcr_pkg::COEF_IDX_W-1:0] in_idx;
  dcr_pkg::coef_t                 in_coef;
  logic [dcr_pkg::PIX_W-1:0]      in_col, in_row;
  logic [dcr_pkg::DEPTH_W-1:0]    in_depth;

  dcr_pkg::coef_t ki [9];
  dcr_pkg::coef_t ce [3][3];
  dcr_pkg::coef_t cr [2][3];
  dcr_pkg::acc_t  ext_init [3];
  dcr_pkg::acc_t  zero_init;

  logic           f_vld, f_zd, f_busy;
  dcr_pkg::acc_t  q [3];
  dcr_pkg::acc_t  t [3];
  dcr_pkg::acc_t  n [2];

  logic [DL-1:0]   vld_t_q, zd_t_q;
  logic [DL-1:0]   vld_n_q;
  dcr_pkg::flags_t fl_n_q [DL];
  dcr_pkg::acc_t   t2_n_q [DL];

  logic                      d_vld, d_busy;
  logic [dcr_pkg::OUT_W-1:0] d_col, d_row;
  logic [dcr_pkg::ST_W-1:0]  d_status;

  logic                      out_vld_q;
  logic [31:0]               out_data_q;
  logic [1:0]                out_user_q;

  // Request fields.
  assign in_idx   = s_axis_tdata[4:0];
  assign in_coef  = s_axis_tdata[52:5];
  assign in_col   = s_axis_tdata[64:53];
  assign in_row   = s_axis_tdata[76:65];
  assign in_depth = s_axis_tdata[92:77];

  // The whole pipeline moves when the output register is free or drained.
  assign adv  = !out_vld_q || m_axis_tready;
  assign busy = f_busy || (|vld_t_q) || (|vld_n_q) || d_busy;

  assign s_axis_tready = adv && !((s_axis_tuser == dcr_pkg::OP_LOAD) && busy);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign map_vld       = accept && (s_axis_tuser == dcr_pkg::OP_MAP);

  // Configuration registers, clamped to the largest image size.
  assign cfg_clamped = (cfg_data_i > dcr_pkg::DIM_W'(dcr_pkg::MAX_DIM)) ?
                       dcr_pkg::DIM_W'(dcr_pkg::MAX_DIM) : cfg_data_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 13'd640;
      height_q <= 13'd480;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        dcr_pkg::REG_WIDTH:  width_q  <= cfg_clamped;
        dcr_pkg::REG_HEIGHT: height_q <= cfg_clamped;
        default: ;
      endcase
    end
  end

  // Coefficient store.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < dcr_pkg::NUM_COEF; i++) begin
        coef_q[i] <= '0;
      end
    end else if (accept && (s_axis_tuser == dcr_pkg::OP_LOAD) &&
                 (in_idx < dcr_pkg::COEF_IDX_W'(dcr_pkg::NUM_COEF))) begin
      coef_q[in_idx] <= in_coef;
    end
  end

  // Coefficient groups for each unit.
  always_comb begin
    for (int i = 0; i < 9; i++) begin
      ki[i] = coef_q[i];
    end
    for (int j = 0; j < 3; j++) begin
      for (int c = 0; c < 3; c++) begin
        ce[j][c] = coef_q[9 + c*3 + j];
      end
      ext_init[j] = dcr_pkg::acc_t'(coef_q[18 + j]);
    end
    for (int k = 0; k < 2; k++) begin
      for (int c = 0; c < 3; c++) begin
        cr[k][c] = coef_q[21 + c*2 + k];
      end
    end
    zero_init = '0;
  end

  dcr_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .vld_i   (map_vld),
    .col_i   (in_col),
    .row_i   (in_row),
    .depth_i (in_depth),
    .ki_i    (ki),
    .vld_o   (f_vld),
    .zd_o    (f_zd),
    .q_o     (q),
    .busy_o  (f_busy)
  );

  // Extrinsic transform: three dot products.
  for (genvar j = 0; j < 3; j++) begin : g_ext
    dcr_dot3 u_dot (
      .clk_i  (clk_i),
      .en_i   (adv),
      .x_i    (q),
      .c_i    (ce[j]),
      .init_i (ext_init[j]),
      .sum_o  (t[j])
    );
  end

  // Color projection: two dot products.
  for (genvar k = 0; k < 2; k++) begin : g_proj
    dcr_dot3 u_dot (
      .clk_i  (clk_i),
      .en_i   (adv),
      .x_i    (t),
      .c_i    (cr[k]),
      .init_i (zero_init),
      .sum_o  (n[k])
    );
  end

  // Valid bits and flags alongside the dot-product units.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_t_q <= '0;
      vld_n_q <= '0;
    end else if (adv) begin
      vld_t_q <= {vld_t_q[DL-2:0], f_vld};
      vld_n_q <= {vld_n_q[DL-2:0], vld_t_q[DL-1]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      zd_t_q               <= {zd_t_q[DL-2:0], f_zd};
      fl_n_q[0].zero_depth <= zd_t_q[DL-1];
      fl_n_q[0].zero_div   <= (t[2] == '0);
      t2_n_q[0]            <= t[2];
      for (int i = 1; i < DL; i++) begin
        fl_n_q[i] <= fl_n_q[i-1];
        t2_n_q[i] <= t2_n_q[i-1];
      end
    end
  end

  dcr_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (adv),
    .vld_i    (vld_n_q[DL-1]),
    .flags_i  (fl_n_q[DL-1]),
    .n0_i     (n[0]),
    .n1_i     (n[1]),
    .d_i      (t2_n_q[DL-1]),
    .width_i  (width_q),
    .height_i (height_q),
    .vld_o    (d_vld),
    .col_o    (d_col),
    .row_o    (d_row),
    .status_o (d_status),
    .busy_o   (d_busy)
  );

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= d_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_data_q <= {d_row, d_col};
      out_user_q <= d_status;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule
